FILE: design/sbmf_pkg.sv
// sbmf_pkg: shared constants, command types and helper functions for the
// separable binary majority filter. No dependencies.
`timescale 1ns / 1ps

package sbmf_pkg;

  localparam int MAX_W   = 1024;
  localparam int MAX_H   = 1024;
  localparam int WINDOW  = 15;
  localparam int HALF    = WINDOW / 2;
  localparam int LINES   = 2 * HALF + 1;
  localparam int MIN_DIM = 16;

  localparam int COL_W  = $clog2(MAX_W);
  localparam int ROW_W  = $clog2(MAX_H);
  localparam int DIM_W  = 11;
  localparam int LANE_W = $clog2(LINES);
  localparam int PIX_W  = 8;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int THR_W  = 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 4'd9;

  localparam logic [DIM_W-1:0] MAX_W_D   = DIM_W'(MAX_W);
  localparam logic [DIM_W-1:0] MAX_H_D   = DIM_W'(MAX_H);
  localparam logic [DIM_W-1:0] MIN_DIM_D = DIM_W'(MIN_DIM);

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  typedef logic [WINDOW-1:0][PIX_W-1:0] win_t;

  // one entry of the front-to-back queue
  typedef struct packed {
    logic              wr_en;
    logic [COL_W-1:0]  addr;
    logic [LANE_W-1:0] lane;
    logic [PIX_W-1:0]  val;
    logic              sub_en;
    logic              emit;
    logic              interior;
    logic [LANE_W-1:0] self_lane;
    logic              frame_end;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              valid;
  } qstat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < MIN_DIM_D) res = MIN_DIM_D;
    else if (v > hi) res = hi;
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] count_zeros(input win_t v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (v[i] == PIX_BLACK) n = n + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [PIX_W-1:0] decide(input logic [CNT_W-1:0] zeros,
                                              input logic [THR_W-1:0] thr);
    return (zeros >= CNT_W'(thr)) ? PIX_BLACK : PIX_WHITE;
  endfunction

  function automatic logic [LANE_W-1:0] lane_inc(input logic [LANE_W-1:0] x);
    return (x == LANE_W'(LINES - 1)) ? '0 : x + 1'b1;
  endfunction

  // line of the row HALF rows above, modulo the line count
  function automatic logic [LANE_W-1:0] lane_back(input logic [LANE_W-1:0] x);
    return (x >= LANE_W'(HALF)) ? x - LANE_W'(HALF) : x + LANE_W'(HALF + 1);
  endfunction

endpackage

FILE: design/sbmf_front.sv
// sbmf_front: accepts pixel and drain transactions, runs the row pass on a
// shift window and issues line store commands. Depends on sbmf_pkg.
`timescale 1ns / 1ps

module sbmf_front import sbmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  input  logic [THR_W-1:0] threshold,
  input  logic             restart,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [PIX_W-1:0] in_pixel_in,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [COL_W-1:0]  col_r, out_col_r;
  logic [ROW_W-1:0]  row_r, out_row_r;
  logic [LANE_W-1:0] line_r, prev_line_r, tail_line_r, out_line_r;
  logic              tail_r;
  win_t              win_r;

  logic [DIM_W-1:0]  eff_w, eff_h;
  logic              accept, pix_acc, drn_acc;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [LANE_W-1:0] cur_line, cur_prev;
  logic [DIM_W-1:0]  c11, r11, oc11, or11, idx_full;
  win_t              win_sh;
  logic [PIX_W-1:0]  row_val;
  logic              col_ge7, col_ge14, last_px, row_end;
  cmd_t              pix_cmd, drn_cmd;

  assign eff_w = clamp_dim(frame_width, MAX_W_D);
  assign eff_h = clamp_dim(frame_height, MAX_H_D);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pix_acc  = accept && !in_req_type;
  assign drn_acc  = accept && in_req_type;

  // a pixel arriving while a tail is pending starts a new frame
  assign cur_col  = tail_r ? '0 : col_r;
  assign cur_row  = tail_r ? '0 : row_r;
  assign cur_line = tail_r ? '0 : line_r;
  assign cur_prev = tail_r ? LANE_W'(LINES - 1) : prev_line_r;

  assign c11  = DIM_W'(cur_col);
  assign r11  = DIM_W'(cur_row);
  assign oc11 = DIM_W'(out_col_r);
  assign or11 = DIM_W'(out_row_r);

  assign win_sh   = {in_pixel_in, win_r[WINDOW-1:1]};
  assign row_val  = decide(count_zeros(win_sh), threshold);
  assign col_ge7  = cur_col >= COL_W'(HALF);
  assign col_ge14 = cur_col >= COL_W'(2 * HALF);
  assign row_end  = c11 == eff_w - DIM_W'(1);
  assign last_px  = row_end && (r11 == eff_h - DIM_W'(1));

  // each pixel finalizes the pixel HALF positions back, which is also the
  // bottom row of the column window emitted on this transaction
  always_comb begin
    pix_cmd.wr_en     = col_ge7 || (cur_row != '0);
    pix_cmd.addr      = col_ge7 ? cur_col - COL_W'(HALF)
                                : COL_W'(c11 + eff_w - DIM_W'(HALF));
    pix_cmd.lane      = col_ge7 ? cur_line : cur_prev;
    pix_cmd.val       = col_ge14 ? row_val : win_sh[HALF];
    pix_cmd.sub_en    = pix_cmd.wr_en;
    pix_cmd.emit      = col_ge7 ? (cur_row >= ROW_W'(HALF))
                                : (cur_row >= ROW_W'(HALF + 1));
    pix_cmd.interior  = col_ge7 ? (cur_row >= ROW_W'(2 * HALF))
                                : (cur_row >= ROW_W'(2 * HALF + 1));
    pix_cmd.self_lane = lane_back(pix_cmd.lane);
    pix_cmd.frame_end = 1'b0;
  end

  // tail: the last row's right edge never reached the line store, take it
  // from the window instead
  assign idx_full = oc11 + DIM_W'(WINDOW) - eff_w;

  always_comb begin
    drn_cmd.wr_en     = 1'b0;
    drn_cmd.addr      = out_col_r;
    drn_cmd.lane      = tail_line_r;
    drn_cmd.val       = win_r[idx_full[LANE_W-1:0]];
    drn_cmd.sub_en    = oc11 >= eff_w - DIM_W'(HALF);
    drn_cmd.emit      = 1'b1;
    drn_cmd.interior  = or11 == eff_h - DIM_W'(HALF + 1);
    drn_cmd.self_lane = out_line_r;
    drn_cmd.frame_end = (oc11 == eff_w - DIM_W'(1)) && (or11 == eff_h - DIM_W'(1));
  end

  assign push     = pix_acc ? pix_cmd.wr_en : (drn_acc && tail_r);
  assign push_cmd = pix_acc ? pix_cmd : drn_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      line_r      <= '0;
      prev_line_r <= LANE_W'(LINES - 1);
      tail_r      <= 1'b0;
      tail_line_r <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_line_r  <= '0;
      win_r       <= '0;
    end else if (restart) begin
      col_r       <= '0;
      row_r       <= '0;
      line_r      <= '0;
      prev_line_r <= LANE_W'(LINES - 1);
      tail_r      <= 1'b0;
    end else if (pix_acc) begin
      win_r <= win_sh;
      if (last_px) begin
        col_r       <= '0;
        row_r       <= '0;
        line_r      <= '0;
        prev_line_r <= LANE_W'(LINES - 1);
        tail_r      <= 1'b1;
        tail_line_r <= cur_line;
        out_col_r   <= COL_W'(eff_w - DIM_W'(HALF));
        out_row_r   <= ROW_W'(eff_h - DIM_W'(HALF + 1));
        out_line_r  <= lane_back(cur_line);
      end else if (row_end) begin
        col_r       <= '0;
        row_r       <= cur_row + 1'b1;
        line_r      <= lane_inc(cur_line);
        prev_line_r <= cur_line;
        tail_r      <= 1'b0;
      end else begin
        col_r       <= cur_col + 1'b1;
        row_r       <= cur_row;
        line_r      <= cur_line;
        prev_line_r <= cur_prev;
        tail_r      <= 1'b0;
      end
    end else if (drn_acc && tail_r) begin
      if (drn_cmd.frame_end) begin
        tail_r <= 1'b0;
      end else if (oc11 == eff_w - DIM_W'(1)) begin
        out_col_r  <= '0;
        out_row_r  <= out_row_r + 1'b1;
        out_line_r <= lane_inc(out_line_r);
      end else begin
        out_col_r <= out_col_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/sbmf_queue.sv
// sbmf_queue: short command queue between the front and back of the
// filter. Depends on sbmf_pkg for cmd_t and the depth.
`timescale 1ns / 1ps

module sbmf_queue import sbmf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t stat
);

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head       = entry_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = count_r == QCNT_W'(QDEPTH);
  assign stat.valid = count_r != '0;

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: design/sbmf_back.sv
// sbmf_back: line store banks, column pass and output register.
// Depends on sbmf_pkg; fed by sbmf_queue.
`timescale 1ns / 1ps

module sbmf_back import sbmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [THR_W-1:0] threshold,
  input  logic             q_valid,
  input  cmd_t             q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel_out,
  output logic             out_frame_end
);

  // one bank per buffered row, all read at the same column
  logic [PIX_W-1:0] line_mem [LINES][MAX_W];
  win_t             rd_r;

  logic             s1_valid_r;
  cmd_t             s1_cmd_r;
  logic             out_valid_r, out_frame_end_r;
  logic [PIX_W-1:0] out_pixel_r;

  logic             out_free, s1_adv, s1_load;
  win_t             col_v;
  logic [PIX_W-1:0] col_val;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || !s1_cmd_r.emit || out_free;
  assign pop      = q_valid && s1_adv;
  assign s1_load  = s1_valid_r && s1_cmd_r.emit && out_free;

  // read returns the old byte of the lane being written; that lane comes
  // from the command itself
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < LINES; i++) begin
        if (q_head.wr_en && (q_head.lane == LANE_W'(i)))
          line_mem[i][q_head.addr] <= q_head.val;
        rd_r[i] <= line_mem[i][q_head.addr];
      end
      s1_cmd_r <= q_head;
    end
  end

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      col_v[i] = (s1_cmd_r.sub_en && (s1_cmd_r.lane == LANE_W'(i))) ? s1_cmd_r.val
                                                                   : rd_r[i];
    end
  end

  assign col_val = s1_cmd_r.interior ? decide(count_zeros(col_v), threshold)
                                     : col_v[s1_cmd_r.self_lane];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      out_pixel_r     <= col_val;
      out_frame_end_r <= s1_cmd_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_frame_end_r;

endmodule

FILE: design/separable_binary_majority_filter.sv
// Top level of the separable binary majority filter: configuration
// registers, front, command queue and back. Depends on sbmf_pkg and submodules.
`timescale 1ns / 1ps

// Streams a binary mask in raster order, one pixel per clock in both
// directions while out_ready is high and the queue is not full. A pixel
// transaction runs the 15-wide row pass, writes one finished row-pass pixel
// into fifteen 1024x8 line banks and, once seven rows plus seven pixels are
// buffered, emits one column-pass result; drain transactions release the
// remaining tail after the last pixel of a frame, the last one flagged by
// out_frame_end. The rate is set by the line banks, which take one write and
// one read per clock. A result passes the front, queue, bank read and column
// vote. Banks are not cleared after reset. Geometry writes restart the frame.

module separable_binary_majority_filter import sbmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] frame_width_r, frame_width_nxt;
  logic [DIM_W-1:0] frame_height_r, frame_height_nxt;
  logic [THR_W-1:0] threshold_r, threshold_nxt;
  logic             cfg_wr, restart;

  logic   q_push, q_pop;
  cmd_t   q_push_cmd, q_head;
  qstat_t q_stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    threshold_nxt    = threshold_r;
    restart          = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data;
          restart         = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data;
          restart          = 1'b1;
        end
        CFG_BLACK_THRESHOLD: begin
          threshold_nxt = cfg_data[THR_W-1:0];
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      threshold_r    <= RST_THRESHOLD;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      threshold_r    <= threshold_nxt;
    end
  end

  sbmf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .threshold    (threshold_r),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_pixel_in  (in_pixel_in),
    .q_full       (q_stat.full),
    .push         (q_push),
    .push_cmd     (q_push_cmd)
  );

  sbmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  sbmf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (threshold_r),
    .q_valid       (q_stat.valid),
    .q_head        (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("command popped from an empty queue");

  a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_stat.count == QCNT_W'($past(q_stat.count) + 1'b1)))
    else $error("queue level did not follow a push");

endmodule
